@@ rtl/y86f_pkg.sv @@
`default_nettype none

package y86f_pkg;

  // operations carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CYCLE = 1'b1;

  // instruction codes
  localparam logic [3:0] IC_HALT  = 4'h0;
  localparam logic [3:0] IC_NOP   = 4'h1;
  localparam logic [3:0] IC_RRMOV = 4'h2;
  localparam logic [3:0] IC_IRMOV = 4'h3;
  localparam logic [3:0] IC_RMMOV = 4'h4;
  localparam logic [3:0] IC_MRMOV = 4'h5;
  localparam logic [3:0] IC_OP    = 4'h6;
  localparam logic [3:0] IC_JXX   = 4'h7;
  localparam logic [3:0] IC_CALL  = 4'h8;
  localparam logic [3:0] IC_RET   = 4'h9;
  localparam logic [3:0] IC_PUSH  = 4'hA;
  localparam logic [3:0] IC_POP   = 4'hB;

  localparam logic [3:0] NO_REG = 4'hF;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // instruction lengths
  localparam logic [3:0] LEN_BARE  = 4'd1;
  localparam logic [3:0] LEN_REGS  = 4'd2;
  localparam logic [3:0] LEN_CONST = 4'd9;
  localparam logic [3:0] LEN_BOTH  = 4'd10;

  // byte banks of the instruction memory
  localparam int unsigned BANKS  = 16;
  localparam int unsigned BANK_W = 4;
  localparam int unsigned FETCH_BYTES = 10;

  typedef struct packed {
    logic [1:0]  pad;
    logic [63:0] wb_loaded_value;
    logic [3:0]  wb_icode;
    logic [63:0] mem_fallthrough;
    logic        mem_cond;
    logic [3:0]  mem_icode;
    logic        stall_req;
    logic [7:0]  write_byte;
    logic [11:0] write_address;
  } in_data_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [63:0] predicted_next;
    logic [63:0] next_sequential;
    logic [63:0] constant_word;
    logic [3:0]  reg_b;
    logic [3:0]  reg_a;
    logic [3:0]  ifun;
    logic [3:0]  icode;
    logic [1:0]  status;
    logic [63:0] fetch_address;
  } out_data_t;

endpackage

`default_nettype wire

@@ rtl/y86_pipeline_fetch_stage.sv @@
// channel  dir  beat fields (lowest bit first)
// s_axis   in   tuser: op / tdata: write_address, write_byte, stall_req, mem_icode,
//               mem_cond, mem_fallthrough, wb_icode, wb_loaded_value, zero pad
// m_axis   out  tdata: fetch_address, status, icode, ifun, reg_a, reg_b,
//               constant_word, next_sequential, predicted_next, zero pad
//
// one beat per cycle in and out while m_axis accepts; cycle beats go via rd_q and pc_q to out_q
// pc select and the banked memory read happen at the input edge, decode in the next cycle
// the loop from read data through decode and next-pc select to the bank address sets the clock
// write beats produce no output beat; MEM_BYTES must be a power of two (the block does not check it)
// reset clears the fetch pc and the pending prediction; memory contents are not cleared
// s_axis stalls only while a decoded beat waits and the output register is held

`default_nettype none

module y86_pipeline_fetch_stage
  import y86f_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,

  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [159:0] s_axis_tdata_i,  // write_address, write_byte, stall_req,
                                             // mem_icode, mem_cond, mem_fallthrough,
                                             // wb_icode, wb_loaded_value
  input  wire logic         s_axis_tuser_i,  // op

  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [279:0]      m_axis_tdata_o   // fetch_address, status, icode, ifun, reg_a,
                                             // reg_b, constant_word, next_sequential,
                                             // predicted_next
);

  localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
  localparam int unsigned ROW_W  = (ADDR_W > BANK_W) ? ADDR_W - BANK_W : 1;
  localparam int unsigned ROWS   = 1 << ROW_W;
  localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'(MEM_BYTES / BANKS - 1);

  in_data_t    in_d;
  logic        acc;
  logic        acc_cyc;
  logic        acc_wr;
  logic        advance;
  logic        out_free;

  logic        s1_v_q, s1_v_d;
  logic        m_valid_q, m_valid_d;
  logic [63:0] fpc_q, fpc_d;
  logic [63:0] pend_q, pend_d;
  logic [63:0] pc_q;
  out_data_t   out_q;
  out_data_t   dec;

  logic [63:0] eff_pend;
  logic [63:0] fpc_new;
  logic [63:0] pc_sel;

  logic [ADDR_W-1:0]  rd_base;
  logic [ADDR_W:0]    rd_ext;
  logic [ROW_W-1:0]   row0;
  logic [ROW_W-1:0]   row1;
  logic [ROW_W-1:0]   rd_row [BANKS];

  logic [ADDR_W+11:0] wa_ext;
  logic [ADDR_W-1:0]  wa;
  logic [ADDR_W:0]    wa_x;
  logic [BANK_W-1:0]  w_bank;
  logic [ROW_W-1:0]   w_row;

  logic [7:0]  rd_q [BANKS];

  assign in_d     = in_data_t'(s_axis_tdata_i);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign advance  = s1_v_q && out_free;

  assign s_axis_tready_o = !s1_v_q || out_free;
  assign acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign acc_cyc = acc && (s_axis_tuser_i == OP_CYCLE);
  assign acc_wr  = acc && (s_axis_tuser_i == OP_WRITE);

  // next pc select
  assign eff_pend = s1_v_q ? dec.predicted_next : pend_q;
  assign fpc_new  = in_d.stall_req ? fpc_q : eff_pend;

  always_comb begin
    priority if (in_d.mem_icode == IC_JXX && !in_d.mem_cond) begin
      pc_sel = in_d.mem_fallthrough;
    end else if (in_d.wb_icode == IC_RET) begin
      pc_sel = in_d.wb_loaded_value;
    end else begin
      pc_sel = fpc_new;
    end
  end

  // bank read rows
  assign rd_base = pc_sel[ADDR_W-1:0];
  assign rd_ext  = {1'b0, rd_base};
  assign row0    = rd_ext[ROW_W+BANK_W-1:BANK_W];
  assign row1    = (row0 + ROW_W'(1)) & ROW_MASK;

  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      rd_row[b] = (BANK_W'(b) < rd_base[BANK_W-1:0]) ? row1 : row0;
    end
  end

  // write address
  assign wa_ext = {{ADDR_W{1'b0}}, in_d.write_address};
  assign wa     = wa_ext[ADDR_W-1:0];
  assign wa_x   = {1'b0, wa};
  assign w_bank = wa[BANK_W-1:0];
  assign w_row  = wa_x[ROW_W+BANK_W-1:BANK_W];

  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    logic [7:0] mem [ROWS];

    always_ff @(posedge clk_i) begin
      if (acc_wr && w_bank == BANK_W'(g)) begin
        mem[w_row] <= in_d.write_byte;
      end
      if (acc_cyc) begin
        rd_q[g] <= mem[rd_row[g]];
      end
    end
  end

  // decode
  always_comb begin
    logic [7:0] ib [FETCH_BYTES];
    logic       regs;
    logic       cons;
    logic [3:0] len;
    for (int k = 0; k < FETCH_BYTES; k++) begin
      ib[k] = rd_q[pc_q[BANK_W-1:0] + BANK_W'(k)];
    end
    dec               = '0;
    dec.fetch_address = pc_q;
    dec.icode         = ib[0][7:4];
    dec.ifun          = ib[0][3:0];
    regs = 1'b0;
    cons = 1'b0;
    unique case (dec.icode)
      IC_RRMOV, IC_OP, IC_PUSH, IC_POP: begin
        regs = 1'b1;
      end
      IC_IRMOV, IC_RMMOV, IC_MRMOV: begin
        regs = 1'b1;
        cons = 1'b1;
      end
      IC_JXX, IC_CALL: begin
        cons = 1'b1;
      end
      default: begin
        regs = 1'b0;
        cons = 1'b0;
      end
    endcase
    if (dec.icode == IC_HALT) begin
      dec.status = ST_HALT;
    end else if (dec.icode > IC_POP) begin
      dec.status = ST_INVALID;
    end else begin
      dec.status = ST_OK;
    end
    dec.reg_a = regs ? ib[1][7:4] : NO_REG;
    dec.reg_b = regs ? ib[1][3:0] : NO_REG;
    for (int i = 0; i < 8; i++) begin
      dec.constant_word[8*i +: 8] = !cons ? 8'h00 : (regs ? ib[i+2] : ib[i+1]);
    end
    priority if (regs && cons) begin
      len = LEN_BOTH;
    end else if (regs) begin
      len = LEN_REGS;
    end else if (cons) begin
      len = LEN_CONST;
    end else begin
      len = LEN_BARE;
    end
    dec.next_sequential = pc_q + {60'd0, len};
    dec.predicted_next  = (dec.icode == IC_JXX || dec.icode == IC_CALL) ?
                          dec.constant_word : dec.next_sequential;
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (acc_cyc) begin
      s1_v_d = 1'b1;
    end else if (advance) begin
      s1_v_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    if (advance) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    fpc_d  = (acc_cyc && !in_d.stall_req) ? eff_pend : fpc_q;
    pend_d = advance ? dec.predicted_next : pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
      fpc_q     <= '0;
      pend_q    <= '0;
    end else begin
      s1_v_q    <= s1_v_d;
      m_valid_q <= m_valid_d;
      fpc_q     <= fpc_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_cyc) begin
      pc_q <= pc_sel;
    end
    if (advance) begin
      out_q <= dec;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  a_s1_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !out_free |=> s1_v_q)
    else $error("decoded beat dropped while output held");

  a_pend_tracks_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> pend_q == out_q.predicted_next)
    else $error("pending prediction differs from last output");

  a_stall_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_cyc && in_d.stall_req |=> fpc_q == $past(fpc_q))
    else $error("fetch pc moved under stall");

  a_bare_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && out_q.next_sequential == out_q.fetch_address + 64'd1
    |-> out_q.reg_a == NO_REG && out_q.reg_b == NO_REG && out_q.constant_word == 64'd0)
    else $error("one-byte instruction with register or constant fields");

  a_halt_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && out_q.status == ST_HALT |-> out_q.icode == IC_HALT)
    else $error("halt status on a non-halt instruction");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import y86f_pkg::*;

  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned FILL_BYTES = 512;
  localparam logic [11:0] FILL_BASE = 12'hF00;
  localparam int unsigned PHASE_ITEMS = 300;

  typedef struct packed {
    logic      op;
    in_data_t  beat;
    logic      typed;
    out_data_t want;
  } plan_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [159:0] s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [279:0] m_axis_tdata_o;

  // predictor state
  logic [7:0]  imem_copy [MEM_BYTES];
  bit          written [MEM_BYTES];
  logic [63:0] pc_reg;
  logic [63:0] pc_pending;

  out_data_t fetch_due_q [$];
  int        errors;
  int        cycles;
  int        src_idle_pct;
  int        sink_stall_pct;
  int        sink_hold;
  out_data_t got;
  out_data_t want;

  y86_pipeline_fetch_stage #(
    .MEM_BYTES(MEM_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [7:0] mem_at(logic [63:0] pc, int unsigned k);
    logic [63:0] a;
    a = pc + k;
    return imem_copy[a[ADDR_W-1:0]];
  endfunction

  function automatic logic fetchable(logic [63:0] pc);
    logic [63:0] a;
    logic        ok;
    ok = 1'b1;
    for (int k = 0; k < 10; k++) begin
      a = pc + 64'(k);
      if (!written[a[ADDR_W-1:0]]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic out_data_t fetch_fields(logic [63:0] pc, logic [1:0] st, logic [3:0] ic,
                                             logic [3:0] fn, logic [3:0] ra, logic [3:0] rb,
                                             logic [63:0] valc, logic [63:0] valp,
                                             logic [63:0] pred);
    out_data_t r;
    r = '0;
    r.fetch_address   = pc;
    r.status          = st;
    r.icode           = ic;
    r.ifun            = fn;
    r.reg_a           = ra;
    r.reg_b           = rb;
    r.constant_word   = valc;
    r.next_sequential = valp;
    r.predicted_next  = pred;
    return r;
  endfunction

  function automatic out_data_t fetch_predict(in_data_t b);
    logic [63:0] pc;
    logic [63:0] valc;
    logic [63:0] valp;
    logic [63:0] pred;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [3:0]  ic;
    logic [3:0]  len;
    logic [1:0]  st;
    logic        regs;
    logic        cons;
    if (!b.stall_req) pc_reg = pc_pending;
    if (b.mem_icode == IC_JXX && !b.mem_cond) begin
      pc = b.mem_fallthrough;
    end else if (b.wb_icode == IC_RET) begin
      pc = b.wb_loaded_value;
    end else begin
      pc = pc_reg;
    end
    b0 = mem_at(pc, 0);
    ic = b0[7:4];
    case (ic)
      IC_RRMOV, IC_OP, IC_PUSH, IC_POP: begin
        regs = 1'b1;
        cons = 1'b0;
      end
      IC_IRMOV, IC_RMMOV, IC_MRMOV: begin
        regs = 1'b1;
        cons = 1'b1;
      end
      IC_JXX, IC_CALL: begin
        regs = 1'b0;
        cons = 1'b1;
      end
      default: begin
        regs = 1'b0;
        cons = 1'b0;
      end
    endcase
    if (ic == IC_HALT) st = ST_HALT;
    else if (ic > IC_POP) st = ST_INVALID;
    else st = ST_OK;
    b1 = regs ? mem_at(pc, 1) : {NO_REG, NO_REG};
    valc = '0;
    if (cons) begin
      for (int i = 0; i < 8; i++) valc[8*i +: 8] = mem_at(pc, (regs ? 2 : 1) + i);
    end
    if (regs && cons) len = LEN_BOTH;
    else if (regs) len = LEN_REGS;
    else if (cons) len = LEN_CONST;
    else len = LEN_BARE;
    valp = pc + {60'd0, len};
    pred = (ic == IC_JXX || ic == IC_CALL) ? valc : valp;
    pc_pending = pred;
    return fetch_fields(pc, st, ic, b0[3:0], b1[7:4], b1[3:0], valc, valp, pred);
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (fetch_due_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = fetch_due_q.pop_front();
        check_field("fetch_address", want.fetch_address, got.fetch_address);
        check_field("status", want.status, got.status);
        check_field("icode", want.icode, got.icode);
        check_field("ifun", want.ifun, got.ifun);
        check_field("reg_a", want.reg_a, got.reg_a);
        check_field("reg_b", want.reg_b, got.reg_b);
        check_field("constant_word", want.constant_word, got.constant_word);
        check_field("next_sequential", want.next_sequential, got.next_sequential);
        check_field("predicted_next", want.predicted_next, got.predicted_next);
      end
    end
  end

  // output side, long hold-off counted here
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_beat(logic op, in_data_t b, logic typed, out_data_t exp_r);
    out_data_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (s_axis_tready_o !== 1'b1) @(posedge clk_i);
    if (op == OP_WRITE) begin
      imem_copy[b.write_address[ADDR_W-1:0]] = b.write_byte;
      written[b.write_address[ADDR_W-1:0]] = 1'b1;
    end else begin
      predicted = fetch_predict(b);
      fetch_due_q.push_back(typed ? exp_r : predicted);
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (fetch_due_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic plan_row_t wr_row(logic [11:0] a, logic [7:0] v);
    plan_row_t r;
    r = '0;
    r.op = OP_WRITE;
    r.beat.write_address = a;
    r.beat.write_byte = v;
    return r;
  endfunction

  function automatic plan_row_t cy_row(logic stall, logic [3:0] mic, logic mc, logic [63:0] ft,
                                      logic [3:0] wic, logic [63:0] wv);
    plan_row_t r;
    r = '0;
    r.op = OP_CYCLE;
    r.beat.stall_req = stall;
    r.beat.mem_icode = mic;
    r.beat.mem_cond = mc;
    r.beat.mem_fallthrough = ft;
    r.beat.wb_icode = wic;
    r.beat.wb_loaded_value = wv;
    return r;
  endfunction

  function automatic plan_row_t with_want(plan_row_t r, out_data_t w);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  task automatic random_item(logic cycles_only);
    in_data_t    b;
    logic        op;
    logic [63:0] fpc;
    logic [63:0] pc;
    b = '0;
    b.write_address   = 12'($urandom);
    b.write_byte      = 8'($urandom);
    b.stall_req       = ($urandom_range(0, 5) == 0);
    b.mem_icode       = ($urandom_range(0, 6) == 0) ? IC_JXX : 4'($urandom);
    b.mem_cond        = 1'($urandom);
    b.mem_fallthrough = {$urandom, $urandom};
    b.wb_icode        = ($urandom_range(0, 6) == 0) ? IC_RET : 4'($urandom);
    b.wb_loaded_value = {$urandom, $urandom};
    // land near the top of memory so operands wrap around
    if ($urandom_range(0, 3) == 0) b.mem_fallthrough[11:4] = 8'hFF;
    if ($urandom_range(0, 3) == 0) b.wb_loaded_value[11:4] = 8'hFF;
    op = (!cycles_only && $urandom_range(0, 9) < 3) ? OP_WRITE : OP_CYCLE;
    if (op == OP_CYCLE) begin
      fpc = b.stall_req ? pc_reg : pc_pending;
      if (b.mem_icode == IC_JXX && !b.mem_cond) pc = b.mem_fallthrough;
      else if (b.wb_icode == IC_RET) pc = b.wb_loaded_value;
      else pc = fpc;
      // steer the fetch back into written bytes
      if (!fetchable(pc)) begin
        b.mem_icode = IC_JXX;
        b.mem_cond  = 1'b0;
        b.mem_fallthrough[11:0] = FILL_BASE + 12'($urandom_range(0, FILL_BYTES - 10));
      end
    end
    // patch bytes the fetch is about to read
    if (op == OP_WRITE && $urandom_range(0, 1) == 1)
      b.write_address = pc_pending[11:0] + 12'($urandom_range(0, 9));
    send_beat(op, b, 1'b0, '0);
  endtask

  initial begin
    plan_row_t plan [$];
    plan_row_t row;
    in_data_t  b;
    out_data_t halt_at0;
    out_data_t bad_at1;
    out_data_t bad_at2;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_WRITE;
    errors          = 0;
    cycles          = 0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    sink_hold       = 0;
    pc_reg          = '0;
    pc_pending      = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill a window around address zero, fetches stay inside written bytes
    for (int a = 0; a < FILL_BYTES; a++) begin
      b = '0;
      b.write_address = FILL_BASE + 12'(a);
      b.write_byte = 8'($urandom);
      send_beat(OP_WRITE, b, 1'b0, '0);
    end

    halt_at0 = fetch_fields(64'd0, ST_HALT, IC_HALT, 4'h0, NO_REG, NO_REG, '0, 64'd1, 64'd1);
    bad_at1 = fetch_fields(64'd1, ST_INVALID, 4'hC, 4'h5, NO_REG, NO_REG, '0, 64'd2, 64'd2);
    bad_at2 = fetch_fields(64'd2, ST_INVALID, 4'hF, 4'hF, NO_REG, NO_REG, '0, 64'd3, 64'd3);

    plan.push_back(wr_row(12'h000, {IC_HALT, 4'h0}));
    plan.push_back(with_want(cy_row(1'b0, IC_NOP, 1'b0, '0, IC_NOP, '0), halt_at0));
    plan.push_back(wr_row(12'hFFF, {IC_NOP, 4'h0}));
    // fallthrough at the top address, next pc wraps to zero
    plan.push_back(with_want(cy_row(1'b0, IC_JXX, 1'b0, '1, IC_NOP, '0),
                             fetch_fields('1, ST_OK, IC_NOP, 4'h0, NO_REG, NO_REG,
                                          '0, '0, '0)));
    plan.push_back(wr_row(12'h001, 8'hC5));
    plan.push_back(with_want(cy_row(1'b0, IC_NOP, 1'b0, '0, IC_RET, 64'd1), bad_at1));
    plan.push_back(wr_row(12'h002, 8'hFF));
    plan.push_back(with_want(cy_row(1'b0, IC_NOP, 1'b0, '0, IC_NOP, '0), bad_at2));
    // mispredict wins over return
    plan.push_back(with_want(cy_row(1'b0, IC_JXX, 1'b0, 64'd1, IC_RET, 64'd2), bad_at1));
    plan.push_back(with_want(cy_row(1'b0, IC_JXX, 1'b1, '0, IC_RET, '0), halt_at0));
    // stall keeps the fetch pc
    plan.push_back(with_want(cy_row(1'b1, IC_NOP, 1'b0, '0, IC_NOP, '0), bad_at2));
    plan.push_back(cy_row(1'b0, IC_NOP, 1'b0, '0, IC_NOP, '0));
    // call whose target bytes wrap past the end of memory
    plan.push_back(wr_row(12'hFFC, {IC_CALL, 4'h0}));
    plan.push_back(wr_row(12'hFFD, 8'h50));
    plan.push_back(wr_row(12'hFFE, 8'h00));
    plan.push_back(cy_row(1'b0, IC_JXX, 1'b0, 64'h8000_0000_0000_0FFC, IC_NOP, '0));
    plan.push_back(cy_row(1'b0, IC_NOP, 1'b0, '0, IC_NOP, '0));
    plan.push_back(wr_row(12'h010, {IC_IRMOV, 4'h0}));
    plan.push_back(cy_row(1'b0, IC_NOP, 1'b0, '0, IC_RET, 64'h10));
    plan.push_back(wr_row(12'h020, {IC_OP, 4'h1}));
    plan.push_back(cy_row(1'b0, IC_JXX, 1'b0, 64'h20, IC_NOP, '0));
    plan.push_back(wr_row(12'h030, {IC_JXX, 4'h3}));
    plan.push_back(wr_row(12'h031, 8'h60));
    plan.push_back(wr_row(12'h032, 8'h00));
    plan.push_back(cy_row(1'b0, IC_NOP, 1'b0, '0, IC_RET, 64'h30));
    plan.push_back(wr_row(12'h040, {IC_POP, 4'h0}));
    plan.push_back(cy_row(1'b0, IC_JXX, 1'b0, 64'hFFFF_FFFF_FFFF_F040, IC_NOP, '0));
    plan.push_back(cy_row(1'b1, IC_NOP, 1'b0, '0, IC_NOP, '0));

    foreach (plan[i]) begin
      row = plan[i];
      send_beat(row.op, row.beat, row.typed, row.want);
    end
    drain();

    // output held off while beats keep coming
    sink_hold = 300;
    for (int n = 0; n < 60; n++) random_item(1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 52;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 52;
        end
        default: begin
          src_idle_pct = 26;
          sink_stall_pct = 26;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) random_item(1'b0);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
